// ===== rtl/core/ogg_page_deframer_assert.svh =====
// assertion macros for the ogg page deframer
// no dependencies; users supply clk and rst_n at the point of use
`ifndef OGG_PAGE_DEFRAMER_ASSERT_SVH
`define OGG_PAGE_DEFRAMER_ASSERT_SVH
`ifndef ASSERT_OFF
`define OGG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ogg deframer assertion failed");
`define OGG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ogg deframer assertion failed");
`else
`define OGG_ASSERT_IMP(lbl, ante, cons)
`define OGG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/ogg_pd_pkg.sv =====
// shared types and constants of the ogg page deframer
// no dependencies
package ogg_pd_pkg;

  localparam int          MAX_SEGMENTS_DEF = 256;
  localparam int          SEG_IDX_W        = 9;
  localparam int          HEADER_LEN       = 27;
  localparam logic [31:0] OGG_MAGIC        = 32'h5367674F;
  localparam logic [31:0] CRC_POLY         = 32'h04C11DB7;
  localparam int          LAST_PAGE_BIT    = 2;
  localparam logic [7:0]  FULL_SEGMENT     = 8'd255;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_FINISHED     = 3'd1,
    ST_BAD_MAGIC    = 3'd2,
    ST_BAD_VERSION  = 3'd3,
    ST_CRC_MISMATCH = 3'd4,
    ST_PREMATURE    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_TABLE   = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CRC, S_EXEC, S_SKIP_RD, S_SKIP_CHK, S_EMIT_DATA, S_LOAD, S_EMIT_STAT
  } state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       source_ended;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic       byte_present;
    logic       packet_end;
    logic [7:0] empty_packets;
    logic [2:0] status_code;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic       clear;
    logic [7:0] data;
  } crc_ctrl_t;

endpackage

// ===== rtl/core/ogg_pd_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module ogg_pd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ogg_pd_crc.sv =====
// bit-serial crc-32 unit, one shift step per cycle, eight per byte
// depends on ogg_pd_pkg
module ogg_pd_crc (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ogg_pd_pkg::crc_ctrl_t ctrl,
  output logic                  busy,
  output logic [31:0]           crc
);
  import ogg_pd_pkg::*;

  logic [31:0] crc_r, crc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (ctrl.clear) begin
      crc_nxt = '0;
    end else if (ctrl.start) begin
      crc_nxt = crc_r ^ {ctrl.data, 24'd0};
      cnt_nxt = 4'd8;
    end else if (cnt_r != 4'd0) begin
      crc_nxt = {crc_r[30:0], 1'b0} ^ (crc_r[31] ? CRC_POLY : 32'd0);
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      cnt_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign busy = (cnt_r != 4'd0);
  assign crc  = crc_r;

endmodule

// ===== rtl/core/ogg_page_deframer.sv =====
// ogg page deframer top level: sequencer, header parser, segment table scan
// depends on ogg_pd_pkg, ogg_pd_crc, ogg_pd_ram, ogg_page_deframer_assert.svh
//
// Takes an Ogg stream one byte per input transfer and returns payload bytes
// with packet-end marks and empty-packet counts, plus one status transfer at
// every page end (ok, stream finished, crc mismatch) or on an error (bad
// magic, bad version, premature end). After any status but ok the block
// halts until reset. The page crc-32 runs through a bit-serial unit, one
// bit per cycle. No new input byte is taken until the last one is done.
// Each header or table byte is accepted, waits on the crc unit (eight shift
// steps, then seeing it done) and is then acted on; a payload byte inside a
// segment also hands over its result. At each segment boundary and at page
// start the segment table memory is scanned, each entry visited being read,
// then checked, and the next segment length is loaded. At page end the crc
// is compared, then the status result is handed over. A pending result
// waits while the result side stalls. No reset clearing pass is needed:
// table entries are always written before they are read.
module ogg_page_deframer #(
  parameter int MAX_SEGMENTS = ogg_pd_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ogg_pd_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ogg_pd_pkg::out_item_t out_data
);
  import ogg_pd_pkg::*;

  localparam int TAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  // control state
  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [4:0]           hidx_r, hidx_nxt;
  logic [SEG_IDX_W-1:0] sidx_r, sidx_nxt;
  logic [7:0]           left_r, left_nxt;
  logic                 halted_r, halted_nxt;
  logic                 open_r, open_nxt;
  logic                 out_valid_r, out_valid_nxt;
  // page header fields
  logic [31:0]          magic_r, magic_nxt;
  logic [7:0]           flags_r, flags_nxt;
  logic [31:0]          stored_r, stored_nxt;
  logic [7:0]           count_r, count_nxt;
  // per-item work registers
  logic [7:0]           byte_r, byte_nxt;
  logic [7:0]           seglen_r, seglen_nxt;
  logic                 pe_r, pe_nxt;
  logic [7:0]           empt_r, empt_nxt;
  logic                 hasb_r, hasb_nxt;
  logic                 first_r, first_nxt;
  logic                 found_r, found_nxt;
  logic                 load_after_r, load_after_nxt;
  status_t              stat_r, stat_nxt;
  out_item_t            out_r, out_nxt;

  crc_ctrl_t            crc_ctrl;
  logic                 crc_busy;
  logic [31:0]          crc_val;

  logic                 ram_we;
  logic [7:0]           ram_rdata;
  logic [SEG_IDX_W-1:0] segs;
  logic                 in_xfer;
  logic                 out_free;
  logic [31:0]          magic_sh;
  logic [SEG_IDX_W-1:0] sidx_inc;
  logic [7:0]           left_dec;
  logic                 idle_payload;

  ogg_pd_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (crc_ctrl),
    .busy  (crc_busy),
    .crc   (crc_val)
  );

  ogg_pd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_SEGMENTS),
    .AW    (TAW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sidx_r[TAW-1:0]),
    .wdata (byte_r),
    .raddr (sidx_r[TAW-1:0]),
    .rdata (ram_rdata)
  );

  // only the first MAX_SEGMENTS entries of a page are kept
  assign segs = ({1'b0, count_r} < SEG_IDX_W'(MAX_SEGMENTS)) ? {1'b0, count_r}
                                                             : SEG_IDX_W'(MAX_SEGMENTS);
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign magic_sh  = {byte_r, magic_r[31:8]};
  assign sidx_inc  = sidx_r + SEG_IDX_W'(1);
  assign left_dec  = left_r - 8'd1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign idle_payload = (state_r == S_IDLE) && (phase_r == PH_PAYLOAD) && !halted_r;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    hidx_nxt       = hidx_r;
    sidx_nxt       = sidx_r;
    left_nxt       = left_r;
    halted_nxt     = halted_r;
    open_nxt       = open_r;
    magic_nxt      = magic_r;
    flags_nxt      = flags_r;
    stored_nxt     = stored_r;
    count_nxt      = count_r;
    byte_nxt       = byte_r;
    seglen_nxt     = seglen_r;
    pe_nxt         = pe_r;
    empt_nxt       = empt_r;
    hasb_nxt       = hasb_r;
    first_nxt      = first_r;
    found_nxt      = found_r;
    load_after_nxt = load_after_r;
    stat_nxt       = stat_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    crc_ctrl       = '0;
    ram_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer && !halted_r) begin
          if (in_data.source_ended) begin
            stat_nxt   = ST_PREMATURE;
            halted_nxt = 1'b1;
            state_nxt  = S_EMIT_STAT;
          end else begin
            byte_nxt       = in_data.data_byte;
            crc_ctrl.start = 1'b1;
            // the stored crc field enters the checksum as zero bytes
            crc_ctrl.data  = (phase_r == PH_HEADER && hidx_r inside {[5'd22:5'd25]})
                             ? 8'd0 : in_data.data_byte;
            state_nxt      = S_CRC;
          end
        end
      end

      S_CRC: begin
        if (!crc_busy) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (phase_r)
          PH_HEADER: begin
            if (hidx_r < 5'd4) begin
              magic_nxt = magic_sh;
            end
            case (hidx_r)
              5'd22:   stored_nxt[7:0]   = byte_r;
              5'd23:   stored_nxt[15:8]  = byte_r;
              5'd24:   stored_nxt[23:16] = byte_r;
              5'd25:   stored_nxt[31:24] = byte_r;
              default: stored_nxt        = stored_r;
            endcase
            if (hidx_r == 5'd3 && magic_sh != OGG_MAGIC) begin
              stat_nxt   = ST_BAD_MAGIC;
              halted_nxt = 1'b1;
              state_nxt  = S_EMIT_STAT;
            end else if (hidx_r == 5'd4 && byte_r != 8'd0) begin
              stat_nxt   = ST_BAD_VERSION;
              halted_nxt = 1'b1;
              state_nxt  = S_EMIT_STAT;
            end else begin
              if (hidx_r == 5'd5) begin
                flags_nxt = byte_r;
              end
              if (hidx_r < 5'(HEADER_LEN - 1)) begin
                hidx_nxt  = hidx_r + 5'd1;
                state_nxt = S_IDLE;
              end else begin
                hidx_nxt  = '0;
                count_nxt = byte_r;
                sidx_nxt  = '0;
                if (byte_r == 8'd0) begin
                  // page without segments: start the page at once
                  pe_nxt         = 1'b0;
                  empt_nxt       = '0;
                  hasb_nxt       = 1'b0;
                  first_nxt      = 1'b1;
                  found_nxt      = 1'b0;
                  load_after_nxt = 1'b1;
                  state_nxt      = S_SKIP_RD;
                end else begin
                  phase_nxt = PH_TABLE;
                  state_nxt = S_IDLE;
                end
              end
            end
          end

          PH_TABLE: begin
            ram_we = (sidx_r < SEG_IDX_W'(MAX_SEGMENTS));
            if (sidx_inc < {1'b0, count_r}) begin
              sidx_nxt  = sidx_inc;
              state_nxt = S_IDLE;
            end else begin
              sidx_nxt       = '0;
              pe_nxt         = 1'b0;
              empt_nxt       = '0;
              hasb_nxt       = 1'b0;
              first_nxt      = 1'b1;
              found_nxt      = 1'b0;
              load_after_nxt = 1'b1;
              state_nxt      = S_SKIP_RD;
            end
          end

          default: begin
            // payload byte
            left_nxt = left_dec;
            hasb_nxt = 1'b1;
            empt_nxt = '0;
            if (left_dec != 8'd0) begin
              open_nxt       = 1'b1;
              pe_nxt         = 1'b0;
              load_after_nxt = 1'b0;
              state_nxt      = S_EMIT_DATA;
            end else begin
              // segment done; a short one closes the packet
              sidx_nxt       = sidx_inc;
              pe_nxt         = (seglen_r < FULL_SEGMENT);
              if (seglen_r == FULL_SEGMENT) begin
                open_nxt = 1'b1;
              end
              first_nxt      = 1'b1;
              found_nxt      = 1'b0;
              load_after_nxt = 1'b1;
              state_nxt      = S_SKIP_RD;
            end
          end
        endcase
      end

      S_SKIP_RD: begin
        if (sidx_r < segs) begin
          state_nxt = S_SKIP_CHK;
        end else begin
          if (pe_r) begin
            open_nxt = 1'b0;
          end
          state_nxt = (hasb_r || pe_r || empt_r != 8'd0) ? S_EMIT_DATA : S_LOAD;
        end
      end

      S_SKIP_CHK: begin
        if (ram_rdata == 8'd0) begin
          // a zero segment right after a full one closes that packet
          if (first_r && !pe_r && open_r) begin
            pe_nxt = 1'b1;
          end else begin
            empt_nxt = empt_r + 8'd1;
          end
          sidx_nxt  = sidx_inc;
          first_nxt = 1'b0;
          state_nxt = S_SKIP_RD;
        end else begin
          found_nxt  = 1'b1;
          seglen_nxt = ram_rdata;
          if (pe_r) begin
            open_nxt = 1'b0;
          end
          state_nxt = (hasb_r || pe_r || empt_r != 8'd0) ? S_EMIT_DATA : S_LOAD;
        end
      end

      S_EMIT_DATA: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.result_kind   = 1'b0;
          out_nxt.payload_byte  = hasb_r ? byte_r : 8'd0;
          out_nxt.byte_present  = hasb_r;
          out_nxt.packet_end    = pe_r;
          out_nxt.empty_packets = empt_r;
          out_nxt.status_code   = ST_OK;
          state_nxt             = load_after_r ? S_LOAD : S_IDLE;
        end
      end

      S_LOAD: begin
        if (found_r) begin
          left_nxt  = seglen_r;
          phase_nxt = PH_PAYLOAD;
          state_nxt = S_IDLE;
        end else begin
          // page end
          if (stored_r != crc_val) begin
            stat_nxt   = ST_CRC_MISMATCH;
            halted_nxt = 1'b1;
          end else if (flags_r[LAST_PAGE_BIT]) begin
            stat_nxt   = ST_FINISHED;
            halted_nxt = 1'b1;
          end else begin
            stat_nxt       = ST_OK;
            phase_nxt      = PH_HEADER;
            hidx_nxt       = '0;
            magic_nxt      = '0;
            stored_nxt     = '0;
            crc_ctrl.clear = 1'b1;
          end
          state_nxt = S_EMIT_STAT;
        end
      end

      S_EMIT_STAT: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.result_kind   = 1'b1;
          out_nxt.payload_byte  = '0;
          out_nxt.byte_present  = 1'b0;
          out_nxt.packet_end    = 1'b0;
          out_nxt.empty_packets = '0;
          out_nxt.status_code   = stat_r;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_HEADER;
      hidx_r      <= '0;
      sidx_r      <= '0;
      left_r      <= '0;
      halted_r    <= 1'b0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
      magic_r     <= '0;
      flags_r     <= '0;
      stored_r    <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      hidx_r      <= hidx_nxt;
      sidx_r      <= sidx_nxt;
      left_r      <= left_nxt;
      halted_r    <= halted_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
      magic_r     <= magic_nxt;
      flags_r     <= flags_nxt;
      stored_r    <= stored_nxt;
      count_r     <= count_nxt;
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    seglen_r     <= seglen_nxt;
    pe_r         <= pe_nxt;
    empt_r       <= empt_nxt;
    hasb_r       <= hasb_nxt;
    first_r      <= first_nxt;
    found_r      <= found_nxt;
    load_after_r <= load_after_nxt;
    stat_r       <= stat_nxt;
    out_r        <= out_nxt;
  end

`include "ogg_page_deframer_assert.svh"

  // halt holds until reset
  `OGG_ASSERT_NXT(a_halt_sticks, halted_r, halted_r)
  // a running block idle in the payload phase always has bytes left in its segment
  `OGG_ASSERT_IMP(a_payload_left, idle_payload, (left_r != 8'd0))
  // the crc unit is never mid-byte while a new transfer can be taken
  `OGG_ASSERT_IMP(a_crc_idle, (state_r == S_IDLE), !crc_busy)

endmodule
